// ===== rtl/core/ppe_pkg.sv =====
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared types, constants and channel placement functions for the palette
// pixel expander.
// ----------------------------------------------------------------------------
`default_nettype none

package ppe_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam int INDEX_W = 8;
    localparam int LEVEL_W = 8;
    localparam int PIXEL_W = 24;
    localparam int NARROW_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int SHIFT_W = 6;
    localparam int SHIFT_AMT_W = 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int OB_DEPTH = 4;

    localparam logic [PIXEL_W-1:0] RST_RED_MASK = 24'h00F800;
    localparam logic [PIXEL_W-1:0] RST_GREEN_MASK = 24'h0007E0;
    localparam logic [PIXEL_W-1:0] RST_BLUE_MASK = 24'h00001F;
    localparam logic RST_WIDE_MODE = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED_MASK = 2'd0,
        CFG_GREEN_MASK = 2'd1,
        CFG_BLUE_MASK = 2'd2,
        CFG_WIDE_MODE = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_CONVERT = 1'b1
    } t_action;

    typedef logic signed [SHIFT_W-1:0] t_shift;

    // One classified item on its way from front to back.
    typedef struct packed {
        logic is_conv;
        logic in_range;
        logic [INDEX_W-1:0] index;
        logic [PIXEL_W-1:0] word;
    } t_cmd;

    typedef struct packed {
        logic wide;
    } t_back_cfg;

    // Smallest k with 2**k >= mask, minus 8.
    function automatic t_shift channel_shift(input logic [PIXEL_W-1:0] mask);
        logic [SHIFT_AMT_W-1:0] k;
        k = SHIFT_AMT_W'(PIXEL_W);
        for (int i = PIXEL_W - 1; i >= 0; i--) begin
            if (((PIXEL_W+1)'(1) << i) >= {1'b0, mask}) begin
                k = SHIFT_AMT_W'(i);
            end
        end
        return $signed({1'b0, k}) - t_shift'(8);
    endfunction

    function automatic logic [PIXEL_W-1:0] place_channel(
        input logic [LEVEL_W-1:0] level,
        input logic [PIXEL_W-1:0] mask,
        input t_shift sh
    );
        logic [PIXEL_W-1:0] ext;
        logic [PIXEL_W-1:0] v;
        logic [SHIFT_AMT_W-1:0] amt;
        ext = {{(PIXEL_W-LEVEL_W){1'b0}}, level};
        if (sh > t_shift'(0)) begin
            amt = SHIFT_AMT_W'(sh);
            v = ext << amt;
        end else begin
            amt = SHIFT_AMT_W'(-sh);
            v = ext >> amt;
        end
        return v & mask;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ppe_in_if.sv =====
// ----------------------------------------------------------------------------
// ppe_in_if
// Input channel: palette writes and convert requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppe_in_if;
    logic valid;
    logic ready;
    logic action;
    logic [ppe_pkg::INDEX_W-1:0] color_index;
    logic [ppe_pkg::LEVEL_W-1:0] red_level;
    logic [ppe_pkg::LEVEL_W-1:0] green_level;
    logic [ppe_pkg::LEVEL_W-1:0] blue_level;

    modport source(
        output valid, action, color_index, red_level, green_level, blue_level,
        input ready
    );
    modport sink(
        input valid, action, color_index, red_level, green_level, blue_level,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/ppe_out_if.sv =====
// ----------------------------------------------------------------------------
// ppe_out_if
// Output channel: packed pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppe_out_if;
    logic valid;
    logic ready;
    logic [ppe_pkg::PIXEL_W-1:0] packed_pixel;

    modport source(output valid, packed_pixel, input ready);
    modport sink(input valid, packed_pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ppe_ram.sv =====
// ----------------------------------------------------------------------------
// ppe_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_ram #(
    parameter int WIDTH = ppe_pkg::PIXEL_W,
    parameter int DEPTH = ppe_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/ppe_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// ppe_cmd_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_cmd_queue #(
    parameter int DEPTH = ppe_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ppe_pkg::t_cmd i_entry,
    output logic               o_full,
    input  wire logic          i_pop,
    output ppe_pkg::t_cmd      o_head,
    output logic               o_head_valid
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ppe_pkg::t_cmd r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_entry;
        end
    end

    assign o_full = (r_cnt == CNT_W'(DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head = r_slot[r_rd];

endmodule

`default_nettype wire

// ===== rtl/core/ppe_front.sv =====
// ----------------------------------------------------------------------------
// ppe_front
// Configuration registers, input acceptance, range check and pixel packing.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_front #(
    parameter int PALETTE_ENTRIES = ppe_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ppe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ppe_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    ppe_in_if.sink                               i_in,
    input  wire logic                            i_queue_full,
    output logic                                 o_push,
    output ppe_pkg::t_cmd                        o_entry,
    output ppe_pkg::t_back_cfg                   o_back_cfg
);

    logic [ppe_pkg::PIXEL_W-1:0] r_red_mask, r_green_mask, r_blue_mask;
    ppe_pkg::t_shift r_red_shift, r_green_shift, r_blue_shift;
    ppe_pkg::t_shift n_wdata_shift;
    logic r_wide;
    logic in_range;

    // Shift follows from the mask, so derive it once at the write.
    assign n_wdata_shift = ppe_pkg::channel_shift(i_cfg_wdata[ppe_pkg::PIXEL_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_mask <= ppe_pkg::RST_RED_MASK;
            r_green_mask <= ppe_pkg::RST_GREEN_MASK;
            r_blue_mask <= ppe_pkg::RST_BLUE_MASK;
            r_red_shift <= ppe_pkg::channel_shift(ppe_pkg::RST_RED_MASK);
            r_green_shift <= ppe_pkg::channel_shift(ppe_pkg::RST_GREEN_MASK);
            r_blue_shift <= ppe_pkg::channel_shift(ppe_pkg::RST_BLUE_MASK);
            r_wide <= ppe_pkg::RST_WIDE_MODE;
        end else if (i_cfg_we) begin
            unique case (ppe_pkg::t_cfg_reg'(i_cfg_index))
                ppe_pkg::CFG_RED_MASK: begin
                    r_red_mask <= i_cfg_wdata[ppe_pkg::PIXEL_W-1:0];
                    r_red_shift <= n_wdata_shift;
                end
                ppe_pkg::CFG_GREEN_MASK: begin
                    r_green_mask <= i_cfg_wdata[ppe_pkg::PIXEL_W-1:0];
                    r_green_shift <= n_wdata_shift;
                end
                ppe_pkg::CFG_BLUE_MASK: begin
                    r_blue_mask <= i_cfg_wdata[ppe_pkg::PIXEL_W-1:0];
                    r_blue_shift <= n_wdata_shift;
                end
                ppe_pkg::CFG_WIDE_MODE: begin
                    r_wide <= i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign in_range = ({1'b0, i_in.color_index} < (ppe_pkg::INDEX_W+1)'(PALETTE_ENTRIES));

    assign i_in.ready = !i_queue_full;
    assign o_push = i_in.valid && !i_queue_full;

    always_comb begin
        o_entry.is_conv = (ppe_pkg::t_action'(i_in.action) == ppe_pkg::ACT_CONVERT);
        o_entry.in_range = in_range;
        o_entry.index = i_in.color_index;
        o_entry.word = ppe_pkg::place_channel(i_in.red_level, r_red_mask, r_red_shift)
                     | ppe_pkg::place_channel(i_in.green_level, r_green_mask, r_green_shift)
                     | ppe_pkg::place_channel(i_in.blue_level, r_blue_mask, r_blue_shift);
    end

    assign o_back_cfg.wide = r_wide;

endmodule

`default_nettype wire

// ===== rtl/core/ppe_back.sv =====
// ----------------------------------------------------------------------------
// ppe_back
// Palette RAM access, read pipeline and output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_back #(
    parameter int PALETTE_ENTRIES = ppe_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ppe_pkg::t_cmd      i_head,
    input  wire logic               i_head_valid,
    output logic                    o_pop,
    input  wire ppe_pkg::t_back_cfg i_cfg,
    ppe_out_if.source               o_out
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam int OB_PTR_W = $clog2(ppe_pkg::OB_DEPTH);
    localparam int OB_CNT_W = $clog2(ppe_pkg::OB_DEPTH + 1);

    logic [ppe_pkg::PIXEL_W-1:0] rdata;
    logic [ppe_pkg::PIXEL_W-1:0] push_word;
    logic ram_we;
    logic credit;
    logic out_pop;

    logic r_s1_valid, r_s1_zero;
    logic [ppe_pkg::PIXEL_W-1:0] r_ob_data [ppe_pkg::OB_DEPTH];
    logic [OB_PTR_W-1:0] r_ob_wr, n_ob_wr;
    logic [OB_PTR_W-1:0] r_ob_rd, n_ob_rd;
    logic [OB_CNT_W-1:0] r_ob_cnt, n_ob_cnt;

    // Reserve a buffer slot for every read in flight so a stalled sink never
    // loses data.
    assign credit = ((r_ob_cnt + OB_CNT_W'(r_s1_valid)) < OB_CNT_W'(ppe_pkg::OB_DEPTH));
    assign o_pop = i_head_valid && (!i_head.is_conv || credit);
    assign ram_we = o_pop && !i_head.is_conv && i_head.in_range;

    ppe_ram #(
        .WIDTH(ppe_pkg::PIXEL_W),
        .DEPTH(PALETTE_ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (i_head.index[AW-1:0]),
        .i_wdata(i_head.word),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_pop && i_head.is_conv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_zero <= !i_head.in_range;
        end
    end

    always_comb begin
        if (r_s1_zero) begin
            push_word = '0;
        end else if (i_cfg.wide) begin
            push_word = rdata;
        end else begin
            push_word = {{(ppe_pkg::PIXEL_W-ppe_pkg::NARROW_W){1'b0}},
                         rdata[ppe_pkg::NARROW_W-1:0]};
        end
    end

    assign out_pop = o_out.valid && o_out.ready;

    always_comb begin
        n_ob_wr = r_ob_wr;
        n_ob_rd = r_ob_rd;
        n_ob_cnt = r_ob_cnt;
        if (r_s1_valid) begin
            n_ob_wr = (r_ob_wr == OB_PTR_W'(ppe_pkg::OB_DEPTH - 1)) ? '0
                                                                   : r_ob_wr + OB_PTR_W'(1);
        end
        if (out_pop) begin
            n_ob_rd = (r_ob_rd == OB_PTR_W'(ppe_pkg::OB_DEPTH - 1)) ? '0
                                                                   : r_ob_rd + OB_PTR_W'(1);
        end
        if (r_s1_valid && !out_pop) begin
            n_ob_cnt = r_ob_cnt + OB_CNT_W'(1);
        end else if (!r_s1_valid && out_pop) begin
            n_ob_cnt = r_ob_cnt - OB_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wr <= '0;
            r_ob_rd <= '0;
            r_ob_cnt <= '0;
        end else begin
            r_ob_wr <= n_ob_wr;
            r_ob_rd <= n_ob_rd;
            r_ob_cnt <= n_ob_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_ob_data[r_ob_wr] <= push_word;
        end
    end

    assign o_out.valid = (r_ob_cnt != '0);
    assign o_out.packed_pixel = r_ob_data[r_ob_rd];

endmodule

`default_nettype wire

// ===== rtl/core/palette_pixel_expander_top.sv =====
// ----------------------------------------------------------------------------
// palette_pixel_expander_top
// Palette lookup that turns 8-bit color indices into packed RGB pixels.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries items with valid/ready. action = write stores the packed
//   red/green/blue levels at color_index; action = convert returns the word
//   stored at color_index on o_out (low 16 bits unless wide mode is set).
//   Indices at or beyond PALETTE_ENTRIES: writes are dropped, converts give 0.
//   Configuration (channel masks, wide mode) is written through i_cfg_we,
//   i_cfg_index, i_cfg_wdata while no item is in flight.
// Throughput and data path:
//   One item per clock sustained while o_out is not stalled, writes and
//   converts mixed freely. A convert passes through the command queue and
//   the registered palette RAM read into the output buffer, from which it is
//   taken on o_out. The single RAM port takes one write or one read per cycle.
// Reset:
//   Masks return to 5-6-5 layout, 16-bit output; queue and buffers empty.
//   Palette contents are not cleared and read as garbage until written.
// Stall:
//   A four-entry output buffer absorbs reads in flight; when it fills the
//   back stops issuing reads, the two-entry queue fills and i_in.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_pixel_expander_top #(
    parameter int PALETTE_ENTRIES = ppe_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ppe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ppe_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    ppe_in_if.sink                              i_in,
    ppe_out_if.source                           o_out
);

    ppe_pkg::t_cmd push_entry;
    ppe_pkg::t_cmd head;
    ppe_pkg::t_back_cfg back_cfg;
    logic push, full, pop, head_valid;

    ppe_front #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_queue_full(full),
        .o_push      (push),
        .o_entry     (push_entry),
        .o_back_cfg  (back_cfg)
    );

    ppe_cmd_queue #(
        .DEPTH(ppe_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_entry     (push_entry),
        .o_full      (full),
        .i_pop       (pop),
        .o_head      (head),
        .o_head_valid(head_valid)
    );

    ppe_back #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_head_valid(head_valid),
        .o_pop       (pop),
        .i_cfg       (back_cfg),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/core/ppe_checker.sv =====
// ----------------------------------------------------------------------------
// ppe_checker
// Port-level checks for the palette pixel expander, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_in_action,
    input wire logic i_out_valid,
    input wire logic i_out_ready
);

    // Converts accepted but not yet delivered; queue, read stage and buffer
    // together hold at most seven.
    logic [3:0] r_pending, n_pending;
    logic conv_in, pix_out;

    assign conv_in = i_in_valid && i_in_ready
                  && (ppe_pkg::t_action'(i_in_action) == ppe_pkg::ACT_CONVERT);
    assign pix_out = i_out_valid && i_out_ready;

    always_comb begin
        n_pending = r_pending;
        if (conv_in && !pix_out) begin
            n_pending = r_pending + 4'd1;
        end else if (!conv_in && pix_out) begin
            n_pending = r_pending - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 4'd0)
        else $error("pixel delivered without a pending convert");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 4'd7)
        else $error("more converts in flight than storage allows");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("not empty and ready after reset");

endmodule

bind palette_pixel_expander_top ppe_checker u_ppe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_in_action(i_in.action),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready)
);

`default_nettype wire
